@@ rtl/core/hhsc_pkg.sv @@
// shared types, constants and register map of the heading hold steer controller
package hhsc_pkg;

  localparam int COUNT_BITS = 24;
  localparam int ADDR_BITS  = 5;

  localparam logic signed [35:0] ACC_LIM  = 36'sd4608000;
  localparam logic [47:0]        SQ_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0]        CROSS_MAX = 16'hFFFF;

  localparam logic [15:0] RST_TARGET = 16'd0;
  localparam logic [11:0] RST_GAIN   = 12'd512;
  localparam logic [8:0]  RST_COEFF  = 9'd90;
  localparam logic [14:0] RST_CENTRE = 15'd9000;
  localparam logic [14:0] RST_LOW    = 15'd6000;
  localparam logic [14:0] RST_HIGH   = 15'd12000;
  localparam logic [14:0] RST_SLEW   = 15'd250;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_GAIN   = 3'd1,
    REG_COEFF  = 3'd2,
    REG_CENTRE = 3'd3,
    REG_LOW    = 3'd4,
    REG_HIGH   = 3'd5,
    REG_SLEW   = 3'd6
  } hhsc_reg_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_ERR   = 3'd1,
    S_MULF  = 3'd2,
    S_ACC   = 3'd3,
    S_MULG  = 3'd4,
    S_SERVO = 3'd5,
    S_DONE  = 3'd6
  } hhsc_state_t;

  typedef enum logic [1:0] {
    MUL_FILT = 2'd0,
    MUL_SQ   = 2'd1,
    MUL_GAIN = 2'd2
  } hhsc_mul_t;

  typedef struct packed {
    logic [15:0] target_heading;
    logic [11:0] gain;
    logic [8:0]  filter_coeff;
    logic [14:0] servo_centre;
    logic [14:0] servo_low_limit;
    logic [14:0] servo_high_limit;
    logic [14:0] slew_step;
  } hhsc_cfg_t;

  typedef struct packed {
    logic      capture;
    logic      err_upd;
    logic      mul_en;
    hhsc_mul_t mul_sel;
    logic      acc_upd;
    logic      metric_upd;
    logic      servo_upd;
    logic      load_out;
  } hhsc_cmd_t;

  typedef struct packed {
    logic sample_valid;
  } hhsc_sts_t;

endpackage

@@ rtl/core/hhsc_cfg.sv @@
// apb register file holding target, gain, filter and servo settings
module hhsc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hhsc_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output hhsc_pkg::hhsc_cfg_t            cfg
);

  hhsc_pkg::hhsc_cfg_t cfg_r;
  hhsc_pkg::hhsc_reg_t reg_sel;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = hhsc_pkg::hhsc_reg_t'(cfg_paddr[4:2]);
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_heading   <= hhsc_pkg::RST_TARGET;
      cfg_r.gain             <= hhsc_pkg::RST_GAIN;
      cfg_r.filter_coeff     <= hhsc_pkg::RST_COEFF;
      cfg_r.servo_centre     <= hhsc_pkg::RST_CENTRE;
      cfg_r.servo_low_limit  <= hhsc_pkg::RST_LOW;
      cfg_r.servo_high_limit <= hhsc_pkg::RST_HIGH;
      cfg_r.slew_step        <= hhsc_pkg::RST_SLEW;
    end else if (wr_en) begin
      unique case (reg_sel)
        hhsc_pkg::REG_TARGET: cfg_r.target_heading   <= cfg_pwdata[15:0];
        hhsc_pkg::REG_GAIN:   cfg_r.gain             <= cfg_pwdata[11:0];
        hhsc_pkg::REG_COEFF:  cfg_r.filter_coeff     <= cfg_pwdata[8:0];
        hhsc_pkg::REG_CENTRE: cfg_r.servo_centre     <= cfg_pwdata[14:0];
        hhsc_pkg::REG_LOW:    cfg_r.servo_low_limit  <= cfg_pwdata[14:0];
        hhsc_pkg::REG_HIGH:   cfg_r.servo_high_limit <= cfg_pwdata[14:0];
        hhsc_pkg::REG_SLEW:   cfg_r.slew_step        <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      hhsc_pkg::REG_TARGET: cfg_prdata = {16'd0, cfg_r.target_heading};
      hhsc_pkg::REG_GAIN:   cfg_prdata = {20'd0, cfg_r.gain};
      hhsc_pkg::REG_COEFF:  cfg_prdata = {23'd0, cfg_r.filter_coeff};
      hhsc_pkg::REG_CENTRE: cfg_prdata = {17'd0, cfg_r.servo_centre};
      hhsc_pkg::REG_LOW:    cfg_prdata = {17'd0, cfg_r.servo_low_limit};
      hhsc_pkg::REG_HIGH:   cfg_prdata = {17'd0, cfg_r.servo_high_limit};
      hhsc_pkg::REG_SLEW:   cfg_prdata = {17'd0, cfg_r.slew_step};
      default:              cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/hhsc_ctrl.sv @@
// sequencing state machine and stream handshakes
module hhsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  hhsc_pkg::hhsc_sts_t sts,
  output hhsc_pkg::hhsc_cmd_t cmd
);

  hhsc_pkg::hhsc_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hhsc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.mul_sel = hhsc_pkg::MUL_FILT;
    unique case (state_r)
      hhsc_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = hhsc_pkg::S_ERR;
        end
      end
      hhsc_pkg::S_ERR: begin
        cmd.err_upd = 1'b1;
        state_nxt   = sts.sample_valid ? hhsc_pkg::S_MULF : hhsc_pkg::S_DONE;
      end
      hhsc_pkg::S_MULF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = hhsc_pkg::MUL_FILT;
        state_nxt   = hhsc_pkg::S_ACC;
      end
      hhsc_pkg::S_ACC: begin
        cmd.acc_upd = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = hhsc_pkg::MUL_SQ;
        state_nxt   = hhsc_pkg::S_MULG;
      end
      hhsc_pkg::S_MULG: begin
        cmd.metric_upd = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = hhsc_pkg::MUL_GAIN;
        state_nxt      = hhsc_pkg::S_SERVO;
      end
      hhsc_pkg::S_SERVO: begin
        cmd.servo_upd = 1'b1;
        state_nxt     = hhsc_pkg::S_DONE;
      end
      hhsc_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = hhsc_pkg::S_IDLE;
        end
      end
      default: state_nxt = hhsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

@@ rtl/core/hhsc_dp.sv @@
// error wrap, filter, gain, slew limit and run metrics with one shared multiplier
module hhsc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  hhsc_pkg::hhsc_cfg_t cfg,
  input  hhsc_pkg::hhsc_cmd_t cmd,
  output hhsc_pkg::hhsc_sts_t sts,
  input  logic [15:0]         in_yaw,
  input  logic                in_yaw_valid,
  input  logic                in_restart,
  output logic [14:0]         servo_cmd,
  output logic [15:0]         heading_error,
  output logic [15:0]         filtered_error,
  output logic [14:0]         peak_error,
  output logic [15:0]         crossings,
  output logic [47:0]         sum_squares,
  output logic [23:0]         sample_count,
  output logic                sample_used
);

  // captured request and working values
  logic signed [15:0] yaw_r;
  logic               valid_r;
  logic signed [15:0] err_r;
  logic signed [41:0] prod_r;

  // loop and metric state
  logic signed [23:0]                acc_r;
  logic [14:0]                       servo_r;
  logic signed [15:0]                last_err_r;
  logic [14:0]                       peak_r;
  logic [15:0]                       cross_r;
  logic [47:0]                       sq_r;
  logic [hhsc_pkg::COUNT_BITS-1:0]   cnt_r;

  // error wrap
  logic signed [15:0] tgt_s;
  logic signed [17:0] hd_diff;
  logic signed [18:0] wr_u, wr_1, wr_2, wr_3, err_w;
  logic signed [15:0] err_nxt;

  // shared multiplier
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] mul_p;
  logic signed [24:0] f_diff;

  // filter update
  logic signed [35:0] acc_sum;
  logic signed [23:0] acc_nxt;

  // servo update
  logic signed [22:0] want, want_c, srv_s, lo_s, hi_s, step_s, delta, delta_c, srv_sum;
  logic [14:0]        servo_nxt;

  // metrics
  logic [48:0]        sq_sum;
  logic [15:0]        mag;
  logic               cross_hit;

  assign sts.sample_valid = valid_r;

  assign tgt_s   = cfg.target_heading;
  assign hd_diff = 18'(tgt_s) - 18'(yaw_r);
  assign wr_u    = 19'(hd_diff) + 19'sd54000;
  assign wr_1    = wr_u[18] ? wr_u + 19'sd36000 : wr_u;
  assign wr_2    = (wr_1 >= 19'sd72000) ? wr_1 - 19'sd72000 : wr_1;
  assign wr_3    = (wr_2 >= 19'sd36000) ? wr_2 - 19'sd36000 : wr_2;
  assign err_w   = wr_3 - 19'sd18000;
  assign err_nxt = err_w[15:0];

  assign f_diff = (25'(err_r) <<< 8) - 25'(acc_r);

  always_comb begin
    case (cmd.mul_sel)
      hhsc_pkg::MUL_FILT: begin
        mul_a = f_diff;
        mul_b = $signed({8'd0, cfg.filter_coeff});
      end
      hhsc_pkg::MUL_SQ: begin
        mul_a = 25'(err_r);
        mul_b = 17'(err_r);
      end
      hhsc_pkg::MUL_GAIN: begin
        mul_a = 25'(acc_r);
        mul_b = $signed({5'd0, cfg.gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    acc_sum = 36'(acc_r) + 36'(prod_r >>> 8);
    if (acc_sum > hhsc_pkg::ACC_LIM) begin
      acc_nxt = 24'(hhsc_pkg::ACC_LIM);
    end else if (acc_sum < -hhsc_pkg::ACC_LIM) begin
      acc_nxt = 24'(-hhsc_pkg::ACC_LIM);
    end else begin
      acc_nxt = acc_sum[23:0];
    end
  end

  always_comb begin
    srv_s  = $signed({8'd0, servo_r});
    lo_s   = $signed({8'd0, cfg.servo_low_limit});
    hi_s   = $signed({8'd0, cfg.servo_high_limit});
    step_s = $signed({8'd0, cfg.slew_step});
    want   = 23'(prod_r >>> 16) + $signed({8'd0, cfg.servo_centre});
    if (want < lo_s) begin
      want_c = lo_s;
    end else if (want > hi_s) begin
      want_c = hi_s;
    end else begin
      want_c = want;
    end
    delta = want_c - srv_s;
    if (delta > step_s) begin
      delta_c = step_s;
    end else if (delta < -step_s) begin
      delta_c = -step_s;
    end else begin
      delta_c = delta;
    end
    srv_sum   = srv_s + delta_c;
    servo_nxt = srv_sum[14:0];
  end

  assign sq_sum    = {1'b0, sq_r} + 49'(prod_r[29:0]);
  assign mag       = err_r[15] ? 16'(-err_r) : 16'(err_r);
  assign cross_hit = (last_err_r < 0 && err_r > 0) || (last_err_r > 0 && err_r < 0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      yaw_r   <= in_yaw;
      valid_r <= in_yaw_valid;
    end
    if (cmd.err_upd) begin
      err_r <= err_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      servo_r    <= hhsc_pkg::RST_CENTRE;
      last_err_r <= '0;
      peak_r     <= '0;
      cross_r    <= '0;
      sq_r       <= '0;
      cnt_r      <= '0;
    end else if (cmd.capture && in_restart) begin
      acc_r      <= '0;
      servo_r    <= cfg.servo_centre;
      last_err_r <= '0;
      peak_r     <= '0;
      cross_r    <= '0;
      sq_r       <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.acc_upd) begin
        acc_r <= acc_nxt;
      end
      if (cmd.metric_upd) begin
        sq_r       <= sq_sum[48] ? hhsc_pkg::SQ_MAX : sq_sum[47:0];
        last_err_r <= err_r;
        if (mag[14:0] > peak_r) begin
          peak_r <= mag[14:0];
        end
        if (cross_hit && cross_r != hhsc_pkg::CROSS_MAX) begin
          cross_r <= cross_r + 16'd1;
        end
        if (cnt_r != '1) begin
          cnt_r <= cnt_r + {{(hhsc_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
        end
      end
      if (cmd.servo_upd) begin
        servo_r <= servo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      servo_cmd      <= servo_r;
      heading_error  <= last_err_r;
      filtered_error <= acc_r[23:8];
      peak_error     <= peak_r;
      crossings      <= cross_r;
      sum_squares    <= sq_r;
      sample_count   <= 24'(cnt_r);
      sample_used    <= valid_r;
    end
  end

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (36'(acc_r) <= hhsc_pkg::ACC_LIM) && (36'(acc_r) >= -hhsc_pkg::ACC_LIM))
    else $error("filter accumulator outside clamp");

  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.metric_upd && !cmd.capture) |=> peak_r >= $past(peak_r))
    else $error("peak error decreased without restart");

  a_restart_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.capture && in_restart) |=> (cnt_r == '0 && sq_r == '0 && acc_r == '0))
    else $error("restart left run state");

endmodule

@@ rtl/core/heading_hold_steer_controller.sv @@
// top level of the heading hold steer controller
// valid sample steps: capture, error wrap, filter multiply, accumulate and square, metrics
// and gain multiply, servo, output load; a dropout sample skips from error wrap to output load
// one sample in work at a time; one 25x17 multiplier is shared for filter, square, gain
// the result register lets the next request be taken while a result waits
// reset: synchronous active low, loads register defaults, clears the run, centres the servo
module heading_hold_steer_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // yaw
  input  logic [1:0]                     in_tuser,   // yaw_valid, restart
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // servo_cmd, heading_error, filtered_error, peak_error, crossings, sum_squares,
  // sample_count, zero pad
  output logic [151:0]                   out_tdata,
  output logic [0:0]                     out_tuser,  // sample_used
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hhsc_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  hhsc_pkg::hhsc_cfg_t cfg;
  hhsc_pkg::hhsc_cmd_t cmd;
  hhsc_pkg::hhsc_sts_t sts;

  logic [14:0] servo_cmd;
  logic [15:0] heading_error;
  logic [15:0] filtered_error;
  logic [14:0] peak_error;
  logic [15:0] crossings;
  logic [47:0] sum_squares;
  logic [23:0] sample_count;
  logic        sample_used;

  hhsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hhsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hhsc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .in_yaw         (in_tdata),
    .in_yaw_valid   (in_tuser[0]),
    .in_restart     (in_tuser[1]),
    .servo_cmd      (servo_cmd),
    .heading_error  (heading_error),
    .filtered_error (filtered_error),
    .peak_error     (peak_error),
    .crossings      (crossings),
    .sum_squares    (sum_squares),
    .sample_count   (sample_count),
    .sample_used    (sample_used)
  );

  assign out_tdata = {2'b00, sample_count, sum_squares, crossings, peak_error,
                      filtered_error, heading_error, servo_cmd};
  assign out_tuser = sample_used;

endmodule

@@ test/heading_hold_steer_controller_tb.sv @@
// self-checking testbench for the heading hold steer controller
`timescale 1ns / 100ps

module heading_hold_steer_controller_tb;

  localparam int     STALL_LIMIT = 3000;
  localparam longint SQ_TOP      = longint'(hhsc_pkg::SQ_MAX);
  localparam longint ACC_TOP     = longint'(hhsc_pkg::ACC_LIM);
  localparam longint COUNT_TOP   = (longint'(1) << hhsc_pkg::COUNT_BITS) - 1;

  typedef struct packed {
    logic [1:0]         pad;
    logic [23:0]        sample_count;
    logic [47:0]        sum_squares;
    logic [15:0]        crossings;
    logic [14:0]        peak_error;
    logic signed [15:0] filtered_error;
    logic signed [15:0] heading_error;
    logic [14:0]        servo_cmd;
  } steer_word_t;

  typedef struct packed {
    logic        used;
    steer_word_t word;
  } steer_expect_t;

  logic                           clk;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [15:0]                    in_tdata    = '0;
  logic [1:0]                     in_tuser    = '0;
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [151:0]                   out_tdata;
  logic [0:0]                     out_tuser;
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [hhsc_pkg::ADDR_BITS-1:0] cfg_paddr   = '0;
  logic [31:0]                    cfg_pwdata  = '0;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  // register copies
  logic signed [15:0] set_target = hhsc_pkg::RST_TARGET;
  logic [11:0]        set_gain   = hhsc_pkg::RST_GAIN;
  logic [8:0]         set_coeff  = hhsc_pkg::RST_COEFF;
  logic [14:0]        set_centre = hhsc_pkg::RST_CENTRE;
  logic [14:0]        set_low    = hhsc_pkg::RST_LOW;
  logic [14:0]        set_high   = hhsc_pkg::RST_HIGH;
  logic [14:0]        set_slew   = hhsc_pkg::RST_SLEW;

  // loop state copies
  int     filt_acc = 0;
  int     servo_at = int'(hhsc_pkg::RST_CENTRE);
  int     prev_err = 0;
  int     peak_mag = 0;
  int     cross_n  = 0;
  longint sq_sum   = 0;
  longint used_n   = 0;

  steer_expect_t pending_steer[$];
  int            mismatches   = 0;
  logic          src_idle_on  = 1'b1;
  logic          sink_idle_on = 1'b1;
  int            hold_left    = 0;

  heading_hold_steer_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic steer_expect_t predict_steer(logic signed [15:0] yaw, logic valid,
                                                  logic restart);
    steer_expect_t r;
    int            err, d, mag;
    longint        acc, want, delta, lim, sq;
    err = prev_err;
    if (restart) begin
      filt_acc = 0;
      prev_err = 0;
      peak_mag = 0;
      cross_n  = 0;
      sq_sum   = 0;
      used_n   = 0;
      servo_at = int'(set_centre);
    end
    if (valid) begin
      d = int'(set_target) - int'(yaw) + 54000;
      d = d % 36000;
      if (d < 0) d += 36000;
      err = d - 18000;

      acc = filt_acc;
      acc += (longint'(set_coeff) * (longint'(err) * 256 - acc)) >>> 8;
      if (acc > ACC_TOP) acc = ACC_TOP;
      if (acc < -ACC_TOP) acc = -ACC_TOP;
      filt_acc = int'(acc);

      want = longint'(set_centre) + ((longint'(set_gain) * acc) >>> 16);
      if (want < longint'(set_low)) want = longint'(set_low);
      else if (want > longint'(set_high)) want = longint'(set_high);

      delta = want - longint'(servo_at);
      lim   = longint'(set_slew);
      if (delta > lim) delta = lim;
      if (delta < -lim) delta = -lim;
      servo_at = int'(longint'(servo_at) + delta);

      sq     = longint'(err) * longint'(err);
      sq_sum = (sq_sum > SQ_TOP - sq) ? SQ_TOP : sq_sum + sq;
      if (used_n < COUNT_TOP) used_n++;
      mag = (err < 0) ? -err : err;
      if (mag > peak_mag) peak_mag = mag;
      if ((prev_err < 0 && err > 0) || (prev_err > 0 && err < 0))
        if (cross_n < int'(hhsc_pkg::CROSS_MAX)) cross_n++;
      prev_err = err;
    end else begin
      err = prev_err;
    end
    r.used                = valid;
    r.word.pad            = '0;
    r.word.servo_cmd      = 15'(servo_at);
    r.word.heading_error  = 16'(err);
    r.word.filtered_error = 16'(filt_acc >>> 8);
    r.word.peak_error     = 15'(peak_mag);
    r.word.crossings      = 16'(cross_n);
    r.word.sum_squares    = 48'(sq_sum);
    r.word.sample_count   = 24'(used_n);
    return r;
  endfunction

  function automatic int pick(int lo, int hi, int wlo, int whi);
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: return lo;
        1: return hi;
        2: return wlo;
        default: return whi;
      endcase
    end
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [15:0] random_yaw();
    int kind, y;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // near the held heading, wrapped into the circle
      y = int'(set_target) + int'($urandom_range(4000)) - 2000;
      if (y > 17999) y -= 36000;
      if (y < -18000) y += 36000;
    end else if (kind < 90) begin
      y = -18000 + int'($urandom_range(35999));
    end else begin
      y = int'($urandom_range(65535));
    end
    return 16'(y);
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic send_sample(input logic [15:0] yaw, input logic valid, input logic restart);
    while (src_idle_on && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= yaw;
    in_tuser  <= {restart, valid};
    do @(posedge clk); while (!in_tready);
    pending_steer.push_back(predict_steer(yaw, valid, restart));
  endtask

  task automatic send_random_sample();
    send_sample(random_yaw(), $urandom_range(99) < 88, $urandom_range(99) < 3);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic apb_write(input hhsc_pkg::hhsc_reg_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic load_settings(input logic [15:0] target, input logic [11:0] gain,
                               input logic [8:0] coeff, input logic [14:0] centre,
                               input logic [14:0] low, input logic [14:0] high,
                               input logic [14:0] slew);
    apb_write(hhsc_pkg::REG_TARGET, 32'(target));
    apb_write(hhsc_pkg::REG_GAIN, 32'(gain));
    apb_write(hhsc_pkg::REG_COEFF, 32'(coeff));
    apb_write(hhsc_pkg::REG_CENTRE, 32'(centre));
    apb_write(hhsc_pkg::REG_LOW, 32'(low));
    apb_write(hhsc_pkg::REG_HIGH, 32'(high));
    apb_write(hhsc_pkg::REG_SLEW, 32'(slew));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    set_target = target;
    set_gain   = gain;
    set_coeff  = coeff;
    set_centre = centre;
    set_low    = low;
    set_high   = high;
    set_slew   = slew;
    @(posedge clk);
  endtask

  task automatic test_wrap_extremes();
    send_sample(16'sd0, 1'b1, 1'b0);
    send_sample(-16'sd18000, 1'b1, 1'b0);
    send_sample(16'sd17999, 1'b1, 1'b0);
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sd9000, 1'b1, 1'b0);
    send_sample(-16'sd9000, 1'b1, 1'b0);
    send_sample(16'sd1, 1'b1, 1'b0);
    send_sample(-16'sd1, 1'b1, 1'b0);
    wait_for_results();
  endtask

  task automatic test_dropout_restart();
    send_sample(16'sd5000, 1'b0, 1'b0);
    send_sample(16'sd5000, 1'b0, 1'b1);
    send_sample(-16'sd12000, 1'b1, 1'b1);
    send_sample(-16'sd12000, 1'b0, 1'b0);
    send_sample(16'sd3000, 1'b1, 1'b0);
    wait_for_results();
  endtask

  task automatic test_receiver_holdoff();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_left    = 400;
    repeat (30) send_random_sample();
    wait_for_results();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_setting_extremes();
    // inverted limits, no slew, coefficient above one
    load_settings(16'sd17999, 12'd4095, 9'd511, 15'd0, 15'd18000, 15'd0, 15'd0);
    send_sample(-16'sd18000, 1'b1, 1'b1);
    send_sample(16'sd0, 1'b1, 1'b0);
    send_sample(16'sd17999, 1'b1, 1'b0);
    wait_for_results();
    load_settings(-16'sd18000, 12'd0, 9'd0, 15'h7FFF, 15'd0, 15'h7FFF, 15'h7FFF);
    send_sample(16'sd17999, 1'b1, 1'b1);
    send_sample(-16'sd17999, 1'b1, 1'b0);
    wait_for_results();
    load_settings(16'h7FFF, 12'd4095, 9'd256, 15'd18000, 15'd0, 15'd18000, 15'd18000);
    send_sample(16'sh8000, 1'b1, 1'b1);
    send_sample(16'sd100, 1'b1, 1'b0);
    send_sample(-16'sd100, 1'b1, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_runs();
    int lo, hi, t;
    for (int phase = 0; phase < 10; phase++) begin
      lo = pick(0, 9000, 0, 32767);
      hi = pick(9000, 18000, 0, 32767);
      if ($urandom_range(9) == 0) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      load_settings(16'(pick(-18000, 17999, -32768, 32767)), 12'(pick(0, 4095, 0, 4095)),
                    9'(pick(0, 256, 0, 511)), 15'(pick(6000, 12000, 0, 32767)),
                    15'(lo), 15'(hi), 15'(pick(1, 600, 0, 32767)));
      src_idle_on  = (phase != 2);
      sink_idle_on = (phase != 2);
      repeat (118) send_random_sample();
      wait_for_results();
    end
  endtask

  // receiver pacing, with a counted hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (sink_idle_on) begin
      out_tready <= ($urandom_range(99) >= 32);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    steer_word_t   got;
    steer_expect_t want;
    if (out_tvalid && out_tready) begin
      if (pending_steer.size() == 0) begin
        $error("result with no request waiting");
        mismatches++;
      end else begin
        want = pending_steer.pop_front();
        got  = steer_word_t'(out_tdata);
        check_field("servo_cmd", want.word.servo_cmd, got.servo_cmd);
        check_field("heading_error", want.word.heading_error, got.heading_error);
        check_field("filtered_error", want.word.filtered_error, got.filtered_error);
        check_field("peak_error", want.word.peak_error, got.peak_error);
        check_field("crossings", want.word.crossings, got.crossings);
        check_field("sum_squares", want.word.sum_squares, got.sum_squares);
        check_field("sample_count", want.word.sample_count, got.sample_count);
        check_field("pad", want.word.pad, got.pad);
        check_field("sample_used", want.used, out_tuser[0]);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("heading_hold_steer_controller_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_wrap_extremes();
    test_dropout_restart();
    test_receiver_holdoff();
    test_setting_extremes();
    test_random_runs();
    if (mismatches == 0 && pending_steer.size() == 0) begin
      $display("heading_hold_steer_controller_tb: PASS");
    end else begin
      $display("heading_hold_steer_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
